/* hdl/sp4q_pkg.sv */
// ----------------------------------------------------------------------------
// Strict-priority queue package
// Shared widths, codes and the command word passed from front to back.
// ----------------------------------------------------------------------------
package sp4q_pkg;

    localparam int NUM_CLASSES     = 4;
    localparam int CLASS_W         = 2;
    localparam int KIND_W          = 2;
    localparam int TCLASS_W        = 3;
    localparam int STATUS_W        = 3;
    localparam int PAYLOAD_W       = 32;
    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_HANDLE_BITS = 32;

    // Request kinds as they arrive on the input channel.
    localparam logic [KIND_W-1:0] KIND_ENQ  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PEEK = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DEQ  = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PEEKED    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_COMPLETED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NONE      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

    // Decoded operation carried through the command queue.
    typedef enum logic [1:0] {
        OP_ENQ  = 2'd0,
        OP_PEEK = 2'd1,
        OP_DEQ  = 2'd2,
        OP_BAD  = 2'd3
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [CLASS_W-1:0] cls;
    } cmd_t;

endpackage

/* hdl/sp4q_ifs.sv */
// ----------------------------------------------------------------------------
// Strict-priority queue channel interfaces
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface sp4q_req_if;
    logic                            valid;
    logic                            ready;
    logic [sp4q_pkg::KIND_W-1:0]     kind;
    logic [sp4q_pkg::TCLASS_W-1:0]   task_class;
    logic [sp4q_pkg::PAYLOAD_W-1:0]  payload;

    modport source (output valid, kind, task_class, payload, input ready);
    modport sink   (input valid, kind, task_class, payload, output ready);
endinterface

interface sp4q_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [sp4q_pkg::STATUS_W-1:0]   status;
    logic [sp4q_pkg::CLASS_W-1:0]    served_class;
    logic [sp4q_pkg::PAYLOAD_W-1:0]  entry_payload;

    modport source (output valid, status, served_class, entry_payload, input ready);
    modport sink   (input valid, status, served_class, entry_payload, output ready);
endinterface

/* hdl/sp4q_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sp4q_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/sp4q_front.sv */
// ----------------------------------------------------------------------------
// Strict-priority queue front end
// Takes request words and decodes them into commands for the back end.
// ----------------------------------------------------------------------------
module sp4q_front #(
    parameter int HANDLE_BITS = sp4q_pkg::DEF_HANDLE_BITS
) (
    sp4q_req_if.sink               req,
    output logic                   cmd_valid,
    input  logic                   cmd_ready,
    output sp4q_pkg::cmd_t         cmd,
    output logic [HANDLE_BITS-1:0] cmd_handle
);

    logic [HANDLE_BITS+sp4q_pkg::PAYLOAD_W-1:0] payload_ext;

    // Handles keep the low HANDLE_BITS bits of the payload, zero-padded if wider.
    assign payload_ext = {{HANDLE_BITS{1'b0}}, req.payload};
    assign cmd_handle  = payload_ext[HANDLE_BITS-1:0];

    assign cmd_valid = req.valid;
    assign req.ready = cmd_ready;

    always_comb
    begin
        cmd.cls = req.task_class[sp4q_pkg::CLASS_W-1:0];
        case (req.kind)
            sp4q_pkg::KIND_ENQ:
            begin
                if (req.task_class < sp4q_pkg::TCLASS_W'(sp4q_pkg::NUM_CLASSES))
                begin
                    cmd.op = sp4q_pkg::OP_ENQ;
                end
                else
                begin
                    cmd.op = sp4q_pkg::OP_BAD;
                end
            end
            sp4q_pkg::KIND_PEEK: cmd.op = sp4q_pkg::OP_PEEK;
            sp4q_pkg::KIND_DEQ:  cmd.op = sp4q_pkg::OP_DEQ;
            default:             cmd.op = sp4q_pkg::OP_BAD;
        endcase
    end

endmodule

/* hdl/sp4q_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// Strict-priority queue command FIFO
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module sp4q_cmd_fifo #(
    parameter int WIDTH = 36
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int FIFO_DEPTH = 2;

    logic [WIDTH-1:0] slot_reg [FIFO_DEPTH];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       fill_reg;
    logic [1:0]       fill_next;
    logic             push;
    logic             pop;

    assign push_ready = (fill_reg != 2'(FIFO_DEPTH));
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hdl/sp4q_back.sv */
// ----------------------------------------------------------------------------
// Strict-priority queue back end
// Holds the four class queues and executes one command at a time.
// ----------------------------------------------------------------------------
module sp4q_back #(
    parameter int QUEUE_DEPTH = sp4q_pkg::DEF_QUEUE_DEPTH,
    parameter int HANDLE_BITS = sp4q_pkg::DEF_HANDLE_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cmd_valid,
    output logic                   cmd_ready,
    input  sp4q_pkg::cmd_t         cmd,
    input  logic [HANDLE_BITS-1:0] cmd_handle,
    sp4q_rsp_if.source             rsp
);

    localparam int PTR_W    = $clog2(QUEUE_DEPTH);
    localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int NCLS     = sp4q_pkg::NUM_CLASSES;
    localparam int CLS_W    = sp4q_pkg::CLASS_W;
    localparam int RAM_DEPTH = NCLS << PTR_W;
    localparam int ADDR_W   = CLS_W + PTR_W;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } state_t;

    state_t                              state_reg, state_next;
    logic [PTR_W-1:0]                    head_reg [NCLS];
    logic [PTR_W-1:0]                    head_next [NCLS];
    logic [PTR_W-1:0]                    tail_reg [NCLS];
    logic [PTR_W-1:0]                    tail_next [NCLS];
    logic [CNT_W-1:0]                    cnt_reg [NCLS];
    logic [CNT_W-1:0]                    cnt_next [NCLS];
    logic [CLS_W-1:0]                    rd_class_reg, rd_class_next;
    logic                                rd_deq_reg, rd_deq_next;
    logic                                out_valid_reg, out_valid_next;
    logic [sp4q_pkg::STATUS_W-1:0]       out_status_reg, out_status_next;
    logic [CLS_W-1:0]                    out_class_reg, out_class_next;
    logic [sp4q_pkg::PAYLOAD_W-1:0]      out_payload_reg, out_payload_next;

    logic                                out_free;
    logic [CLS_W-1:0]                    pick;
    logic                                any_pending;
    logic                                ram_we;
    logic                                ram_re;
    logic [ADDR_W-1:0]                   ram_waddr;
    logic [ADDR_W-1:0]                   ram_raddr;
    logic [HANDLE_BITS-1:0]              ram_rdata;
    logic [HANDLE_BITS+sp4q_pkg::PAYLOAD_W-1:0] rdata_ext;

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    sp4q_ram #(
        .WIDTH (HANDLE_BITS),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (cmd_handle),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rdata_ext = {{sp4q_pkg::PAYLOAD_W{1'b0}}, ram_rdata};

    // Strict priority: the lowest-numbered class with entries wins.
    always_comb
    begin
        pick        = '0;
        any_pending = 1'b0;
        for (int c = NCLS - 1; c >= 0; c--)
        begin
            if (cnt_reg[c] != '0)
            begin
                pick        = CLS_W'(c);
                any_pending = 1'b1;
            end
        end
    end

    assign out_free  = !out_valid_reg || rsp.ready;
    assign cmd_ready = (state_reg == S_IDLE) && out_free;
    assign ram_waddr = {cmd.cls, tail_reg[cmd.cls]};
    assign ram_raddr = {pick, head_reg[pick]};

    always_comb
    begin
        state_next       = state_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        cnt_next         = cnt_reg;
        rd_class_next    = rd_class_reg;
        rd_deq_next      = rd_deq_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_status_next  = out_status_reg;
        out_class_next   = out_class_reg;
        out_payload_next = out_payload_reg;
        ram_we           = 1'b0;
        ram_re           = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    case (cmd.op)
                        sp4q_pkg::OP_ENQ:
                        begin
                            out_valid_next   = 1'b1;
                            out_class_next   = cmd.cls;
                            out_payload_next = '0;
                            if (cnt_reg[cmd.cls] == CNT_W'(QUEUE_DEPTH))
                            begin
                                out_status_next = sp4q_pkg::ST_FULL;
                            end
                            else
                            begin
                                out_status_next     = sp4q_pkg::ST_ADDED;
                                ram_we              = 1'b1;
                                tail_next[cmd.cls]  = advance(tail_reg[cmd.cls]);
                                cnt_next[cmd.cls]   = cnt_reg[cmd.cls] + CNT_W'(1);
                            end
                        end
                        sp4q_pkg::OP_PEEK, sp4q_pkg::OP_DEQ:
                        begin
                            if (any_pending)
                            begin
                                ram_re        = 1'b1;
                                rd_class_next = pick;
                                rd_deq_next   = (cmd.op == sp4q_pkg::OP_DEQ);
                                state_next    = S_READ;
                            end
                            else
                            begin
                                out_valid_next   = 1'b1;
                                out_status_next  = sp4q_pkg::ST_NONE;
                                out_class_next   = '0;
                                out_payload_next = '0;
                            end
                        end
                        default:
                        begin
                            out_valid_next   = 1'b1;
                            out_status_next  = sp4q_pkg::ST_INVALID;
                            out_class_next   = '0;
                            out_payload_next = '0;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                out_valid_next   = 1'b1;
                out_class_next   = rd_class_reg;
                out_payload_next = rdata_ext[sp4q_pkg::PAYLOAD_W-1:0];
                if (rd_deq_reg)
                begin
                    out_status_next         = sp4q_pkg::ST_COMPLETED;
                    head_next[rd_class_reg] = advance(head_reg[rd_class_reg]);
                    cnt_next[rd_class_reg]  = cnt_reg[rd_class_reg] - CNT_W'(1);
                end
                else
                begin
                    out_status_next = sp4q_pkg::ST_PEEKED;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            rd_class_reg  <= '0;
            rd_deq_reg    <= 1'b0;
            for (int c = 0; c < NCLS; c++)
            begin
                head_reg[c] <= '0;
                tail_reg[c] <= '0;
                cnt_reg[c]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            rd_class_reg  <= rd_class_next;
            rd_deq_reg    <= rd_deq_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg  <= out_status_next;
        out_class_reg   <= out_class_next;
        out_payload_reg <= out_payload_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.served_class  = out_class_reg;
    assign rsp.entry_payload = out_payload_reg;

`ifndef SYNTHESIS
    a_read_has_free_output: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> !out_valid_reg)
        else $error("memory read finishing while the output register is occupied");

    a_deq_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ && rd_deq_reg) |-> (cnt_reg[rd_class_reg] != '0))
        else $error("dequeue from an empty class queue");

    a_deq_decrements: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ && rd_deq_reg) |=>
        (cnt_reg[$past(rd_class_reg)] == $past(cnt_reg[rd_class_reg]) - CNT_W'(1)))
        else $error("dequeue did not lower the class entry count");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg[0] <= CNT_W'(QUEUE_DEPTH)) && (cnt_reg[1] <= CNT_W'(QUEUE_DEPTH)) &&
        (cnt_reg[2] <= CNT_W'(QUEUE_DEPTH)) && (cnt_reg[3] <= CNT_W'(QUEUE_DEPTH)))
        else $error("class entry count beyond queue depth");
`endif

endmodule

/* hdl/four_class_strict_priority_queue.sv */
// ----------------------------------------------------------------------------
// Four-class strict-priority queue
// Four FIFO queues of task handles served strictly by class priority.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Word contents
//  --------+-----------+----------------------------------------------
//  req     | in        | kind, task_class, payload
//  rsp     | out       | status, served_class, entry_payload
//
//  An enqueue, an invalid request or a read with nothing pending is answered
//  from the idle state in the back end; a peek or dequeue of a stored entry
//  passes through a read state, for the registered read of the entry memory.
//  A word reaches the back end through a two-entry command queue, so the
//  front end keeps taking up to two words while a result waits.
//  Reset clears pointers and counts at once; the entry memory is not cleared.
//
// The front end decodes each request word into a command (enqueue, peek,
// dequeue, or invalid for an unknown kind or an enqueue to an unknown
// class). The command queue holds up to two decoded words. The back end
// owns the per-class head and tail pointers, the entry counts and the shared
// entry memory, in which class c occupies the rows {c, pointer}. Every request
// gives exactly one result word. Only entries that were written are ever read,
// so the memory needs no clearing pass.
//
module four_class_strict_priority_queue #(
    parameter int QUEUE_DEPTH = sp4q_pkg::DEF_QUEUE_DEPTH,
    parameter int HANDLE_BITS = sp4q_pkg::DEF_HANDLE_BITS
) (
    input  logic       clk,
    input  logic       rst_n,
    sp4q_req_if.sink   req,
    sp4q_rsp_if.source rsp
);

    // A command word is the decoded operation and class, followed by the handle.
    localparam int CMD_BITS = $bits(sp4q_pkg::cmd_t) + HANDLE_BITS;

    logic                   front_valid;
    logic                   front_ready;
    sp4q_pkg::cmd_t         front_cmd;
    logic [HANDLE_BITS-1:0] front_handle;
    logic                   back_valid;
    logic                   back_ready;
    logic [CMD_BITS-1:0]    back_word;
    sp4q_pkg::cmd_t         back_cmd;
    logic [HANDLE_BITS-1:0] back_handle;

    sp4q_front #(
        .HANDLE_BITS (HANDLE_BITS)
    ) u_front (
        .req        (req),
        .cmd_valid  (front_valid),
        .cmd_ready  (front_ready),
        .cmd        (front_cmd),
        .cmd_handle (front_handle)
    );

    sp4q_cmd_fifo #(
        .WIDTH (CMD_BITS)
    ) u_cmd_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  ({front_cmd, front_handle}),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_data   (back_word)
    );

    // Split the queued word back into its command and handle parts.
    assign back_cmd    = sp4q_pkg::cmd_t'(back_word[CMD_BITS-1:HANDLE_BITS]);
    assign back_handle = back_word[HANDLE_BITS-1:0];

    sp4q_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (back_valid),
        .cmd_ready  (back_ready),
        .cmd        (back_cmd),
        .cmd_handle (back_handle),
        .rsp        (rsp)
    );

endmodule

/* test/four_class_strict_priority_queue_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Strict-priority queue checker
// Watches both channels, keeps its own copy of the four class queues, and
// compares every result word with the oldest predicted one.
// ----------------------------------------------------------------------------
module four_class_strict_priority_queue_checker
    import sp4q_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    sp4q_req_if  req,
    sp4q_rsp_if  rsp,
    output int   error_count,
    output int   outstanding,
    output int   words_checked,
    output int   full_refusals,
    output int   empty_reads
);

    localparam int QUEUE_DEPTH = DEF_QUEUE_DEPTH;
    localparam int HANDLE_BITS = DEF_HANDLE_BITS;
    localparam logic [PAYLOAD_W-1:0] HANDLE_MASK =
        (HANDLE_BITS >= PAYLOAD_W) ? '1 : PAYLOAD_W'((64'd1 << HANDLE_BITS) - 64'd1);

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [CLASS_W-1:0]   served_class;
        logic [PAYLOAD_W-1:0] entry_payload;
    } result_word_t;

    logic [PAYLOAD_W-1:0] handles [NUM_CLASSES][QUEUE_DEPTH];
    int                   head_idx  [NUM_CLASSES];
    int                   tail_idx  [NUM_CLASSES];
    int                   occupancy [NUM_CLASSES];
    result_word_t         expected_words [$];

    // Applies one request word to the shadow queues and returns its result.
    function automatic result_word_t serve_request(
        input logic [KIND_W-1:0]    kind,
        input logic [TCLASS_W-1:0]  tcls,
        input logic [PAYLOAD_W-1:0] handle
    );
        result_word_t res;
        int           c;
        int           pick;
        res  = '0;
        pick = NUM_CLASSES;
        if (kind == KIND_ENQ)
        begin
            if (int'(tcls) >= NUM_CLASSES)
            begin
                res.status = ST_INVALID;
            end
            else
            begin
                c                = int'(tcls);
                res.served_class = tcls[CLASS_W-1:0];
                if (occupancy[c] >= QUEUE_DEPTH)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    handles[c][tail_idx[c]] = handle & HANDLE_MASK;
                    tail_idx[c]             = (tail_idx[c] + 1) % QUEUE_DEPTH;
                    occupancy[c]            = occupancy[c] + 1;
                    res.status              = ST_ADDED;
                end
            end
        end
        else if (kind == KIND_PEEK || kind == KIND_DEQ)
        begin
            for (c = NUM_CLASSES - 1; c >= 0; c--)
            begin
                if (occupancy[c] != 0)
                    pick = c;
            end
            if (pick == NUM_CLASSES)
            begin
                res.status = ST_NONE;
            end
            else
            begin
                res.served_class  = pick[CLASS_W-1:0];
                res.entry_payload = handles[pick][head_idx[pick]];
                if (kind == KIND_DEQ)
                begin
                    head_idx[pick]  = (head_idx[pick] + 1) % QUEUE_DEPTH;
                    occupancy[pick] = occupancy[pick] - 1;
                    res.status      = ST_COMPLETED;
                end
                else
                begin
                    res.status = ST_PEEKED;
                end
            end
        end
        else
        begin
            res.status = ST_INVALID;
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        result_word_t want;
        int           bad;
        int           c;
        if (!rst_n)
        begin
            for (c = 0; c < NUM_CLASSES; c++)
            begin
                head_idx[c]  = 0;
                tail_idx[c]  = 0;
                occupancy[c] = 0;
            end
            expected_words.delete();
            error_count   <= 0;
            outstanding   <= 0;
            words_checked <= 0;
            full_refusals <= 0;
            empty_reads   <= 0;
        end
        else
        begin
            // A result word can never belong to a request taken at the same edge,
            // so the response side is settled first.
            if (rsp.valid && rsp.ready)
            begin
                bad = 0;
                words_checked <= words_checked + 1;
                if (rsp.status == ST_FULL)
                    full_refusals <= full_refusals + 1;
                if (rsp.status == ST_NONE)
                    empty_reads <= empty_reads + 1;
                if (expected_words.size() == 0)
                begin
                    $display("%0t: result word with none expected: status %0d class %0d payload %h",
                             $time, rsp.status, rsp.served_class, rsp.entry_payload);
                    bad = 1;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, want.status, rsp.status);
                        bad++;
                    end
                    if (rsp.served_class !== want.served_class)
                    begin
                        $display("%0t: served_class mismatch, expected %0d, got %0d",
                                 $time, want.served_class, rsp.served_class);
                        bad++;
                    end
                    if (rsp.entry_payload !== want.entry_payload)
                    begin
                        $display("%0t: entry_payload mismatch, expected %h, got %h",
                                 $time, want.entry_payload, rsp.entry_payload);
                        bad++;
                    end
                end
                error_count <= error_count + bad;
            end
            if (req.valid && req.ready)
                expected_words.push_back(serve_request(req.kind, req.task_class, req.payload));
            outstanding <= expected_words.size();
        end
    end

endmodule

/* test/four_class_strict_priority_queue_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Strict-priority queue testbench
// Drives request words into the four-class queue and takes its result words
// with random gaps on both sides; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
module four_class_strict_priority_queue_tb;

    import sp4q_pkg::*;

    localparam int HALF_PERIOD     = 6;
    localparam int RESET_CYCLES    = 2;
    localparam int MAX_GAP         = 11;
    // The receiver's long hold-off, well inside the watchdog limit.
    localparam int HOLD_CYCLES     = 300;
    localparam int IDLE_LIMIT      = 2000;
    // Cycles allowed for stray words after the last expected result.
    localparam int TAIL_CYCLES     = 20;
    localparam int RANDOM_PHASES   = 15;
    localparam int WORDS_PER_PHASE = 40;
    localparam int QUEUE_DEPTH     = DEF_QUEUE_DEPTH;
    localparam int FILL_CLASS      = 2;
    localparam int TOP_TASK_CLASS  = (1 << TCLASS_W) - 1;
    // The one kind code that the block has no operation for.
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    sp4q_req_if req_ch ();
    sp4q_rsp_if rsp_ch ();

    int error_count;
    int outstanding;
    int words_checked;
    int full_refusals;
    int empty_reads;
    int words_sent;
    int idle_cycles;
    bit tx_idle;
    bit rx_idle;
    bit hold_request;

    four_class_strict_priority_queue u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    four_class_strict_priority_queue_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req_ch),
        .rsp           (rsp_ch),
        .error_count   (error_count),
        .outstanding   (outstanding),
        .words_checked (words_checked),
        .full_refusals (full_refusals),
        .empty_reads   (empty_reads)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Offers one request word, after a random gap when tx_idle is set, and returns
    // at the edge where it is taken. Valid stays high when the next word follows
    // with no gap, so it is never lowered and raised within one time step.
    task automatic send_word(
        input logic [KIND_W-1:0]    kind,
        input logic [TCLASS_W-1:0]  tcls,
        input logic [PAYLOAD_W-1:0] handle
    );
        int gap;
        gap = tx_idle ? int'($urandom_range(0, MAX_GAP)) : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.kind       <= kind;
        req_ch.task_class <= tcls;
        req_ch.payload    <= handle;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        words_sent++;
    endtask

    // Stops offering words until every predicted result has been taken. The
    // extra edge lets the checker's count take in the word just accepted.
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        @(posedge clk);
    endtask

    // One random request word. Most are well-formed enqueues, peeks and
    // dequeues, with the balance between them set per phase so that queues
    // both run dry and fill up; a small share are invalid classes and the
    // unused kind code. Ignored fields are randomised all the same.
    task automatic random_word(input int enq_pct, input int focus);
        int                  roll;
        logic [KIND_W-1:0]   kind;
        logic [TCLASS_W-1:0] tcls;
        roll = int'($urandom_range(0, 99));
        tcls = TCLASS_W'($urandom_range(0, TOP_TASK_CLASS));
        if (roll < 4)
        begin
            kind = KIND_UNUSED;
        end
        else if (roll < 9)
        begin
            kind = KIND_ENQ;
            tcls = TCLASS_W'($urandom_range(NUM_CLASSES, TOP_TASK_CLASS));
        end
        else if (int'($urandom_range(0, 99)) < enq_pct)
        begin
            kind = KIND_ENQ;
            if (focus >= 0 && $urandom_range(0, 1) == 1)
                tcls = TCLASS_W'(focus);
            else
                tcls = TCLASS_W'($urandom_range(0, NUM_CLASSES - 1));
        end
        else
        begin
            kind = ($urandom_range(0, 2) == 0) ? KIND_PEEK : KIND_DEQ;
        end
        send_word(kind, tcls, $urandom());
    endtask

    // The result side takes words after a random gap of its own when rx_idle is
    // set, and on request holds ready low for a long stretch so that the block backs up.
    initial
    begin : result_sink
        int gap;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            gap = rx_idle ? int'($urandom_range(0, MAX_GAP)) : 0;
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid)
                @(posedge clk);
        end
    end

    // Ends the run if no word moves on either channel for too long.
    initial
    begin : watchdog
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : stimulus
        int enq_pct;
        int focus;
        req_ch.valid      = 1'b0;
        req_ch.kind       = KIND_ENQ;
        req_ch.task_class = '0;
        req_ch.payload    = '0;
        rsp_ch.ready      = 1'b0;
        tx_idle           = 1'b0;
        rx_idle           = 1'b0;
        hold_request      = 1'b0;
        words_sent        = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words. Peek and dequeue with every queue empty come first,
        // then an invalid class at both ends of its range and the unused kind.
        send_word(KIND_PEEK, '0, '0);
        send_word(KIND_DEQ, TCLASS_W'(TOP_TASK_CLASS), '1);
        send_word(KIND_ENQ, TCLASS_W'(NUM_CLASSES), '1);
        send_word(KIND_ENQ, TCLASS_W'(TOP_TASK_CLASS), 32'hA5A5_5A5A);
        send_word(KIND_UNUSED, '0, '1);
        // One entry per class, lowest priority first, with extreme handles, and a
        // second for class 1, so that the dequeues below must come back in strict class order.
        send_word(KIND_ENQ, 3'd3, '1);
        send_word(KIND_ENQ, 3'd2, '0);
        send_word(KIND_ENQ, 3'd1, 32'hAAAA_AAAA);
        send_word(KIND_ENQ, 3'd0, 32'h5555_5555);
        send_word(KIND_ENQ, 3'd1, 32'h8000_0001);
        send_word(KIND_PEEK, 3'd6, 32'hFFFF_0000);
        repeat (5) send_word(KIND_DEQ, TCLASS_W'($urandom_range(0, TOP_TASK_CLASS)), $urandom());
        send_word(KIND_DEQ, '0, '0);
        send_word(KIND_PEEK, '0, '0);
        drain_results();

        // Fill one class past its depth back to back, while the result side
        // holds off, so that the block stalls its input; the last words are
        // refused as full.
        hold_request = 1'b1;
        repeat (QUEUE_DEPTH + 2) send_word(KIND_ENQ, TCLASS_W'(FILL_CLASS), $urandom());
        send_word(KIND_PEEK, '0, '0);
        drain_results();

        // Random phases, each with its own mix of operations, favoured class
        // and idling on either side. Every fifth phase ends with a full drain.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            enq_pct = int'($urandom_range(15, 85));
            focus   = int'($urandom_range(0, NUM_CLASSES));
            if (focus == NUM_CLASSES)
                focus = -1;
            repeat (WORDS_PER_PHASE) random_word(enq_pct, focus);
            if (ph % 5 == 4)
                drain_results();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d request words and %0d result words checked,",
                 words_sent, words_checked);
        $display("with %0d full refusals and %0d reads with nothing pending.",
                 full_refusals, empty_reads);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* four_class_strict_priority_queue.f */
hdl/sp4q_pkg.sv
hdl/sp4q_ifs.sv
hdl/sp4q_ram.sv
hdl/sp4q_front.sv
hdl/sp4q_cmd_fifo.sv
hdl/sp4q_back.sv
hdl/four_class_strict_priority_queue.sv
test/four_class_strict_priority_queue_checker.sv
test/four_class_strict_priority_queue_tb.sv
